// ===== design/sstf_pkg.sv =====
// Shared types and codes for the shortest-seek-time-first request scheduler.
package sstf_pkg;

    localparam int FIELD_SECTOR_BITS = 48;
    localparam int FIELD_COUNT_BITS  = 6;

    localparam logic ACTION_ADD      = 1'b0;
    localparam logic ACTION_DISPATCH = 1'b1;

    typedef enum logic [1:0] {
        STATUS_ADDED      = 2'd0,
        STATUS_FULL       = 2'd1,
        STATUS_DISPATCHED = 2'd2,
        STATUS_EMPTY      = 2'd3
    } sstf_status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FLUSH,
        ST_SETTLE,
        ST_MOVE,
        ST_EMIT
    } sstf_state_t;

    typedef struct packed {
        logic                         action;
        logic [FIELD_SECTOR_BITS-1:0] sector;
    } sstf_req_t;

    typedef struct packed {
        logic [1:0]                   status;
        logic [FIELD_SECTOR_BITS-1:0] sector_out;
        logic [FIELD_COUNT_BITS-1:0]  pending_count;
    } sstf_rsp_t;

    typedef struct packed {
        logic clear;
        logic sample;
    } sstf_scan_ctrl_t;

endpackage

// ===== design/sstf_scan.sv =====
// Two-stage nearest-sector search unit that walks table entries one per cycle.
module sstf_scan #(
    parameter int SECTOR_BITS = 48,
    parameter int IDX_BITS    = 5
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  sstf_pkg::sstf_scan_ctrl_t ctrl,
    input  logic [SECTOR_BITS-1:0]   head,
    input  logic [SECTOR_BITS-1:0]   sample_sector,
    input  logic [IDX_BITS-1:0]      sample_idx,
    output logic [SECTOR_BITS-1:0]   best_sector,
    output logic [IDX_BITS-1:0]      best_idx
);

    logic                   s1_vld_reg;
    logic                   s1_vld_next;
    logic [SECTOR_BITS-1:0] s1_dist_reg;
    logic [SECTOR_BITS-1:0] s1_dist_next;
    logic [SECTOR_BITS-1:0] s1_sec_reg;
    logic [IDX_BITS-1:0]    s1_idx_reg;

    logic                   found_reg;
    logic                   found_next;
    logic [SECTOR_BITS-1:0] best_dist_reg;
    logic [SECTOR_BITS-1:0] best_sec_reg;
    logic [IDX_BITS-1:0]    best_idx_reg;
    logic                   take;

    // Stage one: absolute distance from the head.
    assign s1_vld_next  = ctrl.sample & ~ctrl.clear;
    assign s1_dist_next = (sample_sector >= head) ? (sample_sector - head)
                                                  : (head - sample_sector);

    // Stage two: keep the nearer entry, the lower sector on a tie.
    assign take = s1_vld_reg &&
                  (!found_reg || (s1_dist_reg < best_dist_reg) ||
                   ((s1_dist_reg == best_dist_reg) && (s1_sec_reg < best_sec_reg)));
    assign found_next = ctrl.clear ? 1'b0 : (found_reg | take);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            found_reg  <= 1'b0;
        end
        else
        begin
            s1_vld_reg <= s1_vld_next;
            found_reg  <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_dist_reg <= s1_dist_next;
        s1_sec_reg  <= sample_sector;
        s1_idx_reg  <= sample_idx;
        if (take)
        begin
            best_dist_reg <= s1_dist_reg;
            best_sec_reg  <= s1_sec_reg;
            best_idx_reg  <= s1_idx_reg;
        end
    end

    assign best_sector = best_sec_reg;
    assign best_idx    = best_idx_reg;

endmodule

// ===== design/sstf_request_scheduler.sv =====
// Top level of the shortest-seek-time-first request scheduler with its request table.
//
// Requests enter on the req channel (req_valid / req_stall) and each one gives exactly
// one response on the rsp channel (rsp_valid / rsp_stall). An add request stores its
// sector in the table, or reports the table full. A dispatch request removes the pending
// sector nearest the head position, the lower sector winning a tie, returns it and moves
// the head there; with nothing pending it reports the table empty.
// The table is kept packed in entries 0 to count-1 of a synchronous memory, so the
// pending count doubles as the fill mark and no entry needs a valid bit. Removing an
// entry moves the last entry into the freed place.
// Sequence: an add, or a dispatch with nothing pending, has a loaded response register
// in the cycle after acceptance. A dispatch with entries pending passes through the
// SCAN, FLUSH, SETTLE and MOVE states: the memory read port walks one entry per cycle,
// the two-stage distance search drains during FLUSH and SETTLE, SETTLE reads the last
// entry, and MOVE moves it and loads the response register. One request is worked on
// at a time; req_stall is low whenever the block is idle, even while an earlier
// response still waits in the output register.
// Reset empties the table and returns the head to sector zero at once. While the
// receiver stalls, the response holds and a finished request waits in its final state.
module sstf_request_scheduler #(
    parameter int QUEUE_DEPTH = 32,
    parameter int SECTOR_BITS = 48
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    input  sstf_pkg::sstf_req_t req,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output sstf_pkg::sstf_rsp_t rsp
);

    localparam int IW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    sstf_pkg::sstf_state_t state_reg;
    sstf_pkg::sstf_state_t state_next;

    logic [CW-1:0]          count_reg;
    logic [CW-1:0]          count_next;
    logic [SECTOR_BITS-1:0] head_reg;
    logic [SECTOR_BITS-1:0] head_next;
    logic [IW-1:0]          issue_idx_reg;
    logic [IW-1:0]          issue_idx_next;
    logic                   data_vld_reg;
    logic [IW-1:0]          data_idx_reg;
    logic [SECTOR_BITS-1:0] rd_data_reg;
    sstf_pkg::sstf_rsp_t    res_reg;
    sstf_pkg::sstf_rsp_t    res_next;
    logic                   out_valid_reg;
    sstf_pkg::sstf_rsp_t    out_reg;

    // The table memory.
    logic [SECTOR_BITS-1:0] mem [QUEUE_DEPTH];
    logic                   mem_we;
    logic [IW-1:0]          mem_waddr;
    logic [SECTOR_BITS-1:0] mem_wdata;
    logic [IW-1:0]          mem_raddr;

    logic [CW-1:0]          last_cnt;
    logic [IW-1:0]          last_idx;
    logic [SECTOR_BITS-1:0] sec_in;
    logic                   accept;
    logic                   out_free;
    logic                   table_full;
    logic                   table_empty;

    sstf_pkg::sstf_scan_ctrl_t scan_ctrl;
    logic [SECTOR_BITS-1:0]    best_sector;
    logic [IW-1:0]             best_idx;

    assign last_cnt    = count_reg - CW'(1);
    assign last_idx    = last_cnt[IW-1:0];
    assign sec_in      = SECTOR_BITS'(req.sector);
    assign accept      = req_valid && !req_stall;
    assign out_free    = !out_valid_reg || !rsp_stall;
    assign table_full  = (count_reg == CW'(QUEUE_DEPTH));
    assign table_empty = (count_reg == '0);

    assign req_stall = (state_reg != sstf_pkg::ST_IDLE);

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sstf_pkg::ST_IDLE:
            begin
                if (req_valid)
                begin
                    if ((req.action == sstf_pkg::ACTION_DISPATCH) && !table_empty)
                    begin
                        state_next = sstf_pkg::ST_SCAN;
                    end
                    else
                    begin
                        state_next = sstf_pkg::ST_EMIT;
                    end
                end
            end
            sstf_pkg::ST_SCAN:
            begin
                if (issue_idx_reg == last_idx)
                begin
                    state_next = sstf_pkg::ST_FLUSH;
                end
            end
            sstf_pkg::ST_FLUSH:
            begin
                state_next = sstf_pkg::ST_SETTLE;
            end
            sstf_pkg::ST_SETTLE:
            begin
                state_next = sstf_pkg::ST_MOVE;
            end
            sstf_pkg::ST_MOVE:
            begin
                state_next = sstf_pkg::ST_EMIT;
            end
            sstf_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    state_next = sstf_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = sstf_pkg::ST_IDLE;
            end
        endcase
    end

    // Datapath control for each state.
    always_comb
    begin
        count_next      = count_reg;
        head_next       = head_reg;
        issue_idx_next  = issue_idx_reg;
        res_next        = res_reg;
        mem_we          = 1'b0;
        mem_waddr       = count_reg[IW-1:0];
        mem_wdata       = sec_in;
        mem_raddr       = issue_idx_reg;
        scan_ctrl.clear = 1'b0;
        scan_ctrl.sample = data_vld_reg;
        case (state_reg)
            sstf_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    res_next.sector_out = '0;
                    if (req.action == sstf_pkg::ACTION_ADD)
                    begin
                        if (table_full)
                        begin
                            res_next.status = sstf_pkg::STATUS_FULL;
                        end
                        else
                        begin
                            // The new request goes to the first free place past the packed end.
                            mem_we          = 1'b1;
                            count_next      = count_reg + CW'(1);
                            res_next.status = sstf_pkg::STATUS_ADDED;
                        end
                    end
                    else if (table_empty)
                    begin
                        res_next.status = sstf_pkg::STATUS_EMPTY;
                    end
                    else
                    begin
                        scan_ctrl.clear = 1'b1;
                        issue_idx_next  = '0;
                    end
                    res_next.pending_count = sstf_pkg::FIELD_COUNT_BITS'(count_next);
                end
            end
            sstf_pkg::ST_SCAN:
            begin
                issue_idx_next = issue_idx_reg + IW'(1);
            end
            sstf_pkg::ST_SETTLE:
            begin
                // Fetch the last entry, which fills the place of the one dispatched.
                mem_raddr = last_idx;
            end
            sstf_pkg::ST_MOVE:
            begin
                mem_we                 = 1'b1;
                mem_waddr              = best_idx;
                mem_wdata              = rd_data_reg;
                count_next             = last_cnt;
                head_next              = best_sector;
                res_next.status        = sstf_pkg::STATUS_DISPATCHED;
                res_next.sector_out    = sstf_pkg::FIELD_SECTOR_BITS'(best_sector);
                res_next.pending_count = sstf_pkg::FIELD_COUNT_BITS'(last_cnt);
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sstf_pkg::ST_IDLE;
            count_reg     <= '0;
            head_reg      <= '0;
            data_vld_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            head_reg     <= head_next;
            data_vld_reg <= (state_reg == sstf_pkg::ST_SCAN);
            if ((state_reg == sstf_pkg::ST_EMIT) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        issue_idx_reg <= issue_idx_next;
        data_idx_reg  <= issue_idx_reg;
        res_reg       <= res_next;
        if ((state_reg == sstf_pkg::ST_EMIT) && out_free)
        begin
            out_reg <= res_reg;
        end
    end

    // Synchronous memory with a registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[mem_raddr];
    end

    sstf_scan #(
        .SECTOR_BITS (SECTOR_BITS),
        .IDX_BITS    (IW)
    ) u_scan (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctrl          (scan_ctrl),
        .head          (head_reg),
        .sample_sector (rd_data_reg),
        .sample_idx    (data_idx_reg),
        .best_sector   (best_sector),
        .best_idx      (best_idx)
    );

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

    // The pending count never exceeds the table size.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(QUEUE_DEPTH))
        else $error("pending count beyond table size");

    // A dispatch removes exactly one entry.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == sstf_pkg::ST_MOVE |=> count_reg == $past(last_cnt))
        else $error("dispatch did not remove one entry");

    // The chosen entry lies within the occupied part of the table.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == sstf_pkg::ST_MOVE |-> best_idx <= last_idx)
        else $error("chosen entry outside occupied range");

    // A new response appears only after a request has finished.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(state_reg == sstf_pkg::ST_EMIT))
        else $error("response without a finished request");

endmodule

// ===== tb/sstf_checker.sv =====
// Checker that predicts and compares every response of the request scheduler.
`timescale 1ns / 1ps

module sstf_checker #(
    parameter int DEPTH = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    input  logic                req_stall,
    input  sstf_pkg::sstf_req_t req,
    input  logic                rsp_valid,
    input  logic                rsp_stall,
    input  sstf_pkg::sstf_rsp_t rsp,
    output int                  mismatches,
    output int                  awaited
);

    logic [sstf_pkg::FIELD_SECTOR_BITS-1:0] table_sector [DEPTH];
    bit                                     table_used [DEPTH];
    logic [sstf_pkg::FIELD_SECTOR_BITS-1:0] head_sector;
    int                                     pending_total;
    sstf_pkg::sstf_rsp_t                    awaited_responses [$];
    int                                     mismatch_total;

    task automatic report_mismatch(input string what);
        mismatch_total++;
        if (mismatch_total <= 40)
        begin
            $display("mismatch at %0t ns: %s", $time, what);
        end
    endtask

    // Applies one request to the predicted table and returns the response it should give.
    function automatic sstf_pkg::sstf_rsp_t schedule_request(input sstf_pkg::sstf_req_t r);
        sstf_pkg::sstf_rsp_t                    res;
        int                                     slot;
        int                                     best;
        logic [sstf_pkg::FIELD_SECTOR_BITS-1:0] seek_gap;
        logic [sstf_pkg::FIELD_SECTOR_BITS-1:0] best_dist;
        res = '0;
        slot = -1;
        best = -1;
        best_dist = '0;
        if (r.action == sstf_pkg::ACTION_ADD)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                if (!table_used[i] && slot < 0)
                begin
                    slot = i;
                end
            end
            if (slot >= 0)
            begin
                table_sector[slot] = r.sector;
                table_used[slot] = 1'b1;
                pending_total++;
                res.status = sstf_pkg::STATUS_ADDED;
            end
            else
            begin
                res.status = sstf_pkg::STATUS_FULL;
            end
        end
        else
        begin
            // Nearest sector to the head; the lower sector wins a tie, then the lower slot.
            for (int i = 0; i < DEPTH; i++)
            begin
                if (table_used[i])
                begin
                    seek_gap = (table_sector[i] >= head_sector)
                               ? table_sector[i] - head_sector
                               : head_sector - table_sector[i];
                    if (best < 0 || seek_gap < best_dist ||
                        (seek_gap == best_dist && table_sector[i] < table_sector[best]))
                    begin
                        best = i;
                        best_dist = seek_gap;
                    end
                end
            end
            if (best >= 0)
            begin
                res.sector_out = table_sector[best];
                table_used[best] = 1'b0;
                pending_total--;
                head_sector = table_sector[best];
                res.status = sstf_pkg::STATUS_DISPATCHED;
            end
            else
            begin
                res.status = sstf_pkg::STATUS_EMPTY;
            end
        end
        res.pending_count = sstf_pkg::FIELD_COUNT_BITS'(pending_total);
        return res;
    endfunction

    always @(posedge clk)
    begin
        sstf_pkg::sstf_rsp_t wanted;
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                table_used[i] = 1'b0;
            end
            head_sector = '0;
            pending_total = 0;
            awaited_responses.delete();
            mismatch_total = 0;
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (awaited_responses.size() == 0)
                begin
                    report_mismatch("response with no request awaiting it");
                end
                else
                begin
                    wanted = awaited_responses.pop_front();
                    if (rsp.status !== wanted.status)
                    begin
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  rsp.status, wanted.status));
                    end
                    if (rsp.sector_out !== wanted.sector_out)
                    begin
                        report_mismatch($sformatf("sector_out %h, expected %h",
                                                  rsp.sector_out, wanted.sector_out));
                    end
                    if (rsp.pending_count !== wanted.pending_count)
                    begin
                        report_mismatch($sformatf("pending_count %0d, expected %0d",
                                                  rsp.pending_count, wanted.pending_count));
                    end
                end
            end
            if (req_valid && !req_stall)
            begin
                awaited_responses.push_back(schedule_request(req));
            end
        end
        mismatches = mismatch_total;
        awaited = awaited_responses.size();
    end

endmodule

// ===== tb/tb_sstf_request_scheduler.sv =====
// Testbench top for the request scheduler: clock, reset, request stimulus and verdict.
`timescale 1ns / 1ps

module tb_sstf_request_scheduler;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int TOTAL_ITEMS = 1700;
    localparam logic [sstf_pkg::FIELD_SECTOR_BITS-1:0] SECTOR_MAX = '1;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                req_valid;
    logic                req_stall;
    sstf_pkg::sstf_req_t req;
    logic                rsp_valid;
    logic                rsp_stall = 1'b0;
    sstf_pkg::sstf_rsp_t rsp;

    int mismatches;
    int awaited;
    int cycle_count = 0;
    int sent = 0;
    int stall_left = 0;
    bit quiet = 1'b0;
    bit rsp_taken = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    sstf_request_scheduler dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    sstf_checker u_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .req        (req),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .rsp        (rsp),
        .mismatches (mismatches),
        .awaited    (awaited)
    );

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        rsp_taken <= rsp_valid && !rsp_stall;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // After each response taken, the receiver draws how long it holds off the next one.
    always @(negedge clk)
    begin
        if (rsp_taken)
        begin
            stall_left = quiet ? 0 : $urandom_range(0, 14);
        end
        if (stall_left > 0)
        begin
            rsp_stall <= 1'b1;
            stall_left--;
        end
        else
        begin
            rsp_stall <= 1'b0;
        end
    end

    // Often small sectors so that ties and duplicates are common, some near the top, the rest random.
    function automatic logic [sstf_pkg::FIELD_SECTOR_BITS-1:0] pick_sector();
        int          roll;
        logic [63:0] wide;
        roll = $urandom_range(0, 99);
        wide = {$urandom, $urandom};
        if (roll < 40)
        begin
            return sstf_pkg::FIELD_SECTOR_BITS'($urandom_range(0, 63));
        end
        else if (roll < 55)
        begin
            return SECTOR_MAX - sstf_pkg::FIELD_SECTOR_BITS'($urandom_range(0, 63));
        end
        return wide[sstf_pkg::FIELD_SECTOR_BITS-1:0];
    endfunction

    // Called at a falling edge; returns at the falling edge after the request is taken.
    task automatic send_request(input logic act,
                                input logic [sstf_pkg::FIELD_SECTOR_BITS-1:0] sec);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 14);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_valid <= 1'b1;
        req <= '{action: act, sector: sec};
        do
        begin
            @(posedge clk);
        end
        while (req_stall);
        sent++;
        @(negedge clk);
    endtask

    initial
    begin
        int seg_len;
        int add_pct;
        rst_n = 1'b0;
        req_valid = 1'b0;
        req = '0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: empty table, the sector extremes, a tie and duplicate sectors.
        send_request(sstf_pkg::ACTION_DISPATCH, SECTOR_MAX);
        send_request(sstf_pkg::ACTION_ADD, '0);
        send_request(sstf_pkg::ACTION_ADD, SECTOR_MAX);
        send_request(sstf_pkg::ACTION_DISPATCH, '0);
        send_request(sstf_pkg::ACTION_DISPATCH, '0);
        send_request(sstf_pkg::ACTION_DISPATCH, '0);
        send_request(sstf_pkg::ACTION_ADD, 48'd1000);
        send_request(sstf_pkg::ACTION_DISPATCH, '0);
        send_request(sstf_pkg::ACTION_ADD, 48'd1010);
        send_request(sstf_pkg::ACTION_ADD, 48'd990);
        send_request(sstf_pkg::ACTION_DISPATCH, '0);
        send_request(sstf_pkg::ACTION_ADD, 48'd7);
        send_request(sstf_pkg::ACTION_ADD, 48'd7);
        send_request(sstf_pkg::ACTION_ADD, 48'hAAAA_AAAA_AAAA);
        send_request(sstf_pkg::ACTION_ADD, 48'h5555_5555_5555);
        send_request(sstf_pkg::ACTION_DISPATCH, '0);
        send_request(sstf_pkg::ACTION_DISPATCH, '0);
        send_request(sstf_pkg::ACTION_DISPATCH, '0);
        send_request(sstf_pkg::ACTION_DISPATCH, '0);
        send_request(sstf_pkg::ACTION_DISPATCH, '0);
        send_request(sstf_pkg::ACTION_DISPATCH, '0);

        // Random segments that lean towards adding or dispatching, so the table
        // often runs full and often runs dry.
        while (sent < TOTAL_ITEMS)
        begin
            seg_len = $urandom_range(10, 60);
            case ($urandom_range(0, 2))
                0:       add_pct = 90;
                1:       add_pct = 50;
                default: add_pct = 15;
            endcase
            quiet = ($urandom_range(0, 3) == 0);
            repeat (seg_len)
            begin
                send_request(($urandom_range(0, 99) < add_pct) ? sstf_pkg::ACTION_ADD
                                                               : sstf_pkg::ACTION_DISPATCH,
                             pick_sector());
            end
        end
        quiet = 1'b0;
        req_valid <= 1'b0;

        wait (awaited == 0);
        repeat (60) @(negedge clk);
        if (mismatches == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
